/* hdl/gqvg_pkg.sv */
// Shared types, constants and helpers of the glyph quad vertex generator.
// Used by every module of the block except gqvg_ram; depends on nothing.
`default_nettype none

package gqvg_pkg;

  localparam int GLYPH_COUNT_DEF  = 65536;
  localparam int GLYPH_HEIGHT_DEF = 16;

  // request function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  localparam logic [15:0] SPACE_CODE    = 16'h0020;
  localparam logic [3:0]  NIBBLE_MASK   = 4'hF;
  localparam logic signed [17:0] SPACE_ADVANCE = 18'sd6;
  localparam logic signed [17:0] GLYPH_GAP     = 18'sd2;

  localparam logic [2:0] LAST_VERTEX_IDX = 3'd5;

  // one quad, ready to be walked through its six vertices
  typedef struct packed {
    logic signed [15:0] x0;
    logic signed [15:0] x1;
    logic signed [15:0] y0;
    logic signed [15:0] y1;
    logic [4:0]         s_col;
    logic [4:0]         e_col;
    logic [31:0]        color;
    logic [15:0]        id;
  } quad_t;

  typedef struct packed {
    logic  push;
    quad_t quad;
  } quad_req_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [17:0] ext18(input logic signed [15:0] v);
    return {{2{v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

/* hdl/gqvg_ram.sv */
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module gqvg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/gqvg_setup.sv */
// Render stage: takes the glyph size read back from the RAM, keeps the pen,
// builds the quad corners and advances the pen. Depends on gqvg_pkg.
`default_nettype none

module gqvg_setup #(
  parameter int GLYPH_HEIGHT = gqvg_pkg::GLYPH_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               acc_render,
  input  wire logic               in_rng,
  input  wire logic               first_of_string,
  input  wire logic [15:0]        codepoint,
  input  wire logic signed [15:0] start_x,
  input  wire logic signed [15:0] start_y,
  input  wire logic [31:0]        color_rgba,
  input  wire logic [7:0]         rdata,
  input  wire logic               quad_free,
  output gqvg_pkg::quad_req_t     quad_req,
  output logic                    s1_busy,
  output logic                    s1_ready
);

  localparam logic signed [17:0] HEIGHT_EXT = 18'(GLYPH_HEIGHT);

  logic                      s1_valid_r, s1_valid_nxt;
  logic                      first_r, rng_r;
  logic [15:0]               code_r;
  logic signed [15:0]        sx_r, sy_r;
  logic [31:0]               color_r;
  logic signed [15:0]        pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;

  logic signed [15:0]        pen_x_cur, pen_y_cur;
  logic [7:0]                entry;
  logic [4:0]                s_col, e_col;
  logic signed [5:0]         w;
  logic                      is_space, done;

  always_comb begin
    pen_x_cur = first_r ? sx_r : pen_x_r;
    pen_y_cur = first_r ? sy_r : pen_y_r;
    entry     = rng_r ? rdata : 8'h00;
    s_col     = {1'b0, (entry[7:4] & gqvg_pkg::NIBBLE_MASK)};
    e_col     = {1'b0, (entry[3:0] & gqvg_pkg::NIBBLE_MASK)} + 5'd1;
    w         = $signed({1'b0, e_col}) - $signed({1'b0, s_col});
    is_space  = (code_r == gqvg_pkg::SPACE_CODE);
    done      = s1_valid_r && (is_space || quad_free);

    quad_req.push       = s1_valid_r && !is_space && quad_free;
    quad_req.quad.x0    = pen_x_cur;
    quad_req.quad.x1    = gqvg_pkg::sat16(gqvg_pkg::ext18(pen_x_cur) + 18'(w));
    quad_req.quad.y0    = pen_y_cur;
    quad_req.quad.y1    = gqvg_pkg::sat16(gqvg_pkg::ext18(pen_y_cur) + HEIGHT_EXT);
    quad_req.quad.s_col = s_col;
    quad_req.quad.e_col = e_col;
    quad_req.quad.color = color_r;
    quad_req.quad.id    = code_r;

    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (done) begin
      pen_y_nxt = pen_y_cur;
      if (is_space) begin
        pen_x_nxt = gqvg_pkg::sat16(gqvg_pkg::ext18(pen_x_cur) + gqvg_pkg::SPACE_ADVANCE);
      end else begin
        pen_x_nxt = gqvg_pkg::sat16(gqvg_pkg::ext18(pen_x_cur) + 18'(w)
                                    + gqvg_pkg::GLYPH_GAP);
      end
    end

    if (acc_render) begin
      s1_valid_nxt = 1'b1;
    end else if (done) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pen_x_r    <= '0;
      pen_y_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      pen_x_r    <= pen_x_nxt;
      pen_y_r    <= pen_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_render) begin
      first_r <= first_of_string;
      rng_r   <= in_rng;
      code_r  <= codepoint;
      sx_r    <= start_x;
      sy_r    <= start_y;
      color_r <= color_rgba;
    end
  end

  assign s1_busy  = s1_valid_r;
  assign s1_ready = !s1_valid_r || done;

endmodule

`default_nettype wire

/* hdl/gqvg_emit.sv */
// Vertex sequencer: holds one quad and walks it through six vertices into
// the output register. Depends on gqvg_pkg.
`default_nettype none

module gqvg_emit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gqvg_pkg::quad_req_t quad_req,
  output logic                     quad_free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [15:0]       out_vertex_x,
  output logic signed [15:0]       out_vertex_y,
  output logic [5:0]               out_uv_packed,
  output logic [31:0]              out_vertex_color,
  output logic [15:0]              out_char_code,
  output logic                     out_last_vertex
);

  gqvg_pkg::quad_t    q_r;
  logic               q_valid_r, q_valid_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               load_out, is_last;

  logic signed [15:0] vx, vy;
  logic [4:0]         col;
  logic               row;

  logic signed [15:0] x_r, y_r;
  logic [5:0]         uv_r;
  logic [31:0]        color_r;
  logic [15:0]        id_r;
  logic               last_r;

  always_comb begin
    load_out  = q_valid_r && (!out_valid_r || out_ready);
    is_last   = (idx_r == gqvg_pkg::LAST_VERTEX_IDX);
    quad_free = !q_valid_r || (load_out && is_last);

    // two triangles: (0,0)(0,H)(w,0) and (w,0)(0,H)(w,H)
    case (idx_r)
      3'd0: begin vx = q_r.x0; vy = q_r.y0; col = q_r.s_col; row = 1'b0; end
      3'd1: begin vx = q_r.x0; vy = q_r.y1; col = q_r.s_col; row = 1'b1; end
      3'd2: begin vx = q_r.x1; vy = q_r.y0; col = q_r.e_col; row = 1'b0; end
      3'd3: begin vx = q_r.x1; vy = q_r.y0; col = q_r.e_col; row = 1'b0; end
      3'd4: begin vx = q_r.x0; vy = q_r.y1; col = q_r.s_col; row = 1'b1; end
      default: begin vx = q_r.x1; vy = q_r.y1; col = q_r.e_col; row = 1'b1; end
    endcase

    q_valid_nxt = q_valid_r;
    idx_nxt     = idx_r;
    if (quad_req.push && quad_free) begin
      q_valid_nxt = 1'b1;
      idx_nxt     = '0;
    end else if (load_out) begin
      idx_nxt = idx_r + 3'd1;
      if (is_last) begin
        q_valid_nxt = 1'b0;
      end
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      q_valid_r   <= q_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (quad_req.push && quad_free) begin
      q_r <= quad_req.quad;
    end
    if (load_out) begin
      x_r     <= vx;
      y_r     <= vy;
      uv_r    <= {col, row};
      color_r <= q_r.color;
      id_r    <= q_r.id;
      last_r  <= is_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_x     = x_r;
  assign out_vertex_y     = y_r;
  assign out_uv_packed    = uv_r;
  assign out_vertex_color = color_r;
  assign out_char_code    = id_r;
  assign out_last_vertex  = last_r;

endmodule

`default_nettype wire

/* hdl/glyph_quad_vertex_generator.sv */
// Top level of the glyph quad vertex generator: glyph size RAM, render stage
// and vertex sequencer. Depends on gqvg_pkg, gqvg_ram, gqvg_setup, gqvg_emit.
//
// Load requests (func 0) write one glyph size entry; a load at or beyond
// GLYPH_COUNT is dropped. Render requests read the entry, set up the quad
// from the pen and advance the pen; a space only advances it. Each glyph
// produces six vertices, one per cycle through the output register while
// out_ready is high, and the next glyph's quad is taken as its last vertex
// is loaded; spaces and loads run at one per cycle as long as the render
// stage is not held. An accepted glyph passes the RAM read, the quad setup
// and the output register before its first vertex appears. The glyph size
// RAM has no reset: render only codepoints whose entry was loaded.
`default_nettype none

module glyph_quad_vertex_generator #(
  parameter int GLYPH_COUNT  = gqvg_pkg::GLYPH_COUNT_DEF,
  parameter int GLYPH_HEIGHT = gqvg_pkg::GLYPH_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic               in_first_of_string,
  input  wire logic [15:0]        in_codepoint,
  input  wire logic [7:0]         in_entry_value,
  input  wire logic signed [15:0] in_start_x,
  input  wire logic signed [15:0] in_start_y,
  input  wire logic [31:0]        in_color_rgba,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_vertex_x,
  output logic signed [15:0]      out_vertex_y,
  output logic [5:0]              out_uv_packed,
  output logic [31:0]             out_vertex_color,
  output logic [15:0]             out_char_code,
  output logic                    out_last_vertex
);

  localparam int AW = $clog2(GLYPH_COUNT);

  logic                accept, in_rng, acc_render, ram_we;
  logic [7:0]          rdata;
  logic                quad_free, s1_busy, s1_ready;
  gqvg_pkg::quad_req_t quad_req;

  assign in_ready   = s1_ready;
  assign accept     = in_valid && in_ready;
  assign in_rng     = {1'b0, in_codepoint} < 17'(GLYPH_COUNT);
  assign acc_render = accept && (in_func == gqvg_pkg::FUNC_RENDER);
  assign ram_we     = accept && (in_func == gqvg_pkg::FUNC_LOAD) && in_rng;

  gqvg_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_COUNT)
  ) u_sizes (
    .clk   (clk),
    .we    (ram_we),
    .re    (acc_render),
    .addr  (in_codepoint[AW-1:0]),
    .wdata (in_entry_value),
    .rdata (rdata)
  );

  gqvg_setup #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_setup (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc_render      (acc_render),
    .in_rng          (in_rng),
    .first_of_string (in_first_of_string),
    .codepoint       (in_codepoint),
    .start_x         (in_start_x),
    .start_y         (in_start_y),
    .color_rgba      (in_color_rgba),
    .rdata           (rdata),
    .quad_free       (quad_free),
    .quad_req        (quad_req),
    .s1_busy         (s1_busy),
    .s1_ready        (s1_ready)
  );

  gqvg_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .quad_req         (quad_req),
    .quad_free        (quad_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_uv_packed    (out_uv_packed),
    .out_vertex_color (out_vertex_color),
    .out_char_code    (out_char_code),
    .out_last_vertex  (out_last_vertex)
  );

  // inside a quad the next vertex follows without a gap
  a_quad_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_vertex |=> out_valid)
    else $error("vertex stream gapped inside a quad");

  // an accepted render request sits in the render stage next cycle
  a_render_staged: assert property (@(posedge clk) disable iff (!rst_n)
    acc_render |=> s1_busy)
    else $error("render request lost before setup");

  // a stalled busy stage blocks requests; vacuous, push needs quad_free
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    quad_req.push && !quad_free |-> !in_ready)
    else $error("request accepted while quad setup stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for glyph_quad_vertex_generator: loads glyph size
// entries, renders codepoints and checks every vertex against a local
// prediction of the pen and quad arithmetic. Depends on gqvg_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic        FN_LOAD   = gqvg_pkg::FUNC_LOAD;
  localparam logic        FN_RENDER = gqvg_pkg::FUNC_RENDER;
  localparam logic [15:0] SPACE_CP  = gqvg_pkg::SPACE_CODE;

  typedef struct packed {
    logic               func;
    logic               first;
    logic [15:0]        code;
    logic [7:0]         entry;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [31:0]        color;
  } glyph_req_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [5:0]         uv;
    logic [31:0]        color;
    logic [15:0]        id;
    logic               last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  wire  in_ready;
  wire  out_valid;
  wire  signed [15:0] out_vertex_x;
  wire  signed [15:0] out_vertex_y;
  wire  [5:0]  out_uv_packed;
  wire  [31:0] out_vertex_color;
  wire  [15:0] out_char_code;
  wire  out_last_vertex;

  glyph_req_t cur_req = '0;
  glyph_req_t next_req;
  glyph_req_t req_q[$];
  vertex_t    vertex_q[$];
  vertex_t    want_v;

  // predictor state
  logic [7:0] size_mem[logic [15:0]];
  int pen_x = 0;
  int pen_y = 0;

  // stimulus bookkeeping: which codepoints have an entry
  logic [15:0] known_codes[$];
  bit          code_known[logic [15:0]];

  int idle_pct = 0;
  int stall_pct = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  glyph_quad_vertex_generator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (cur_req.func),
    .in_first_of_string (cur_req.first),
    .in_codepoint       (cur_req.code),
    .in_entry_value     (cur_req.entry),
    .in_start_x         (cur_req.sx),
    .in_start_y         (cur_req.sy),
    .in_color_rgba      (cur_req.color),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_vertex_x       (out_vertex_x),
    .out_vertex_y       (out_vertex_y),
    .out_uv_packed      (out_uv_packed),
    .out_vertex_color   (out_vertex_color),
    .out_char_code      (out_char_code),
    .out_last_vertex    (out_last_vertex)
  );

  function automatic int clamp_px(input int v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  task automatic push_vertex(input int x, input int y, input int col, input int row,
                             input glyph_req_t r, input logic last);
    vertex_t v;
    int xc;
    int yc;
    xc = clamp_px(x);
    yc = clamp_px(y);
    v.x = xc[15:0];
    v.y = yc[15:0];
    v.uv = 6'((col << 1) | (row & 1));
    v.color = r.color;
    v.id = r.code;
    v.last = last;
    vertex_q.push_back(v);
  endtask

  // Applies one accepted request to the pen and size table and queues the
  // six vertices of a glyph quad when it renders a glyph other than a space.
  task automatic predict_glyph(input glyph_req_t r);
    logic [7:0] ent;
    int sc;
    int ec;
    int w;
    if (r.func == FN_LOAD) begin
      if (int'(r.code) < gqvg_pkg::GLYPH_COUNT_DEF) begin
        size_mem[r.code] = r.entry;
      end
      return;
    end
    if (r.first) begin
      pen_x = r.sx;
      pen_y = r.sy;
    end
    if (r.code == SPACE_CP) begin
      pen_x = clamp_px(pen_x + int'(gqvg_pkg::SPACE_ADVANCE));
      return;
    end
    ent = size_mem.exists(r.code) ? size_mem[r.code] : 8'h00;
    sc = ent[7:4];
    ec = ent[3:0] + 1;
    w = ec - sc;
    push_vertex(pen_x, pen_y, sc, 0, r, 1'b0);
    push_vertex(pen_x, pen_y + gqvg_pkg::GLYPH_HEIGHT_DEF, sc, 1, r, 1'b0);
    push_vertex(pen_x + w, pen_y, ec, 0, r, 1'b0);
    push_vertex(pen_x + w, pen_y, ec, 0, r, 1'b0);
    push_vertex(pen_x, pen_y + gqvg_pkg::GLYPH_HEIGHT_DEF, sc, 1, r, 1'b0);
    push_vertex(pen_x + w, pen_y + gqvg_pkg::GLYPH_HEIGHT_DEF, ec, 1, r, 1'b1);
    pen_x = clamp_px(pen_x + w + int'(gqvg_pkg::GLYPH_GAP));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  task automatic queue_req(input logic func, input logic first, input logic [15:0] code,
                           input logic [7:0] entry, input logic [15:0] sx,
                           input logic [15:0] sy, input logic [31:0] color);
    glyph_req_t r;
    r.func = func;
    r.first = first;
    r.code = code;
    r.entry = entry;
    r.sx = sx;
    r.sy = sy;
    r.color = color;
    if (func == FN_LOAD && !code_known.exists(code)) begin
      code_known[code] = 1'b1;
      known_codes.push_back(code);
    end
    req_q.push_back(r);
  endtask

  function automatic logic [15:0] pick_start();
    int k;
    k = $urandom_range(99);
    if (k < 8) begin
      return 16'h7FFF;
    end
    if (k < 16) begin
      return 16'h8000;
    end
    return 16'($urandom());
  endfunction

  // Mostly well-formed: loads of random entries interleaved with renders of
  // loaded glyphs, with spaces and pen reloads mixed in.
  task automatic gen_random(input int n);
    int k;
    logic [15:0] code;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 25) begin
        code = ($urandom_range(1) == 0) ? 16'($urandom()) : 16'($urandom_range(8'h21, 8'h7E));
        queue_req(FN_LOAD, 1'($urandom()), code, 8'($urandom()), pick_start(),
                  pick_start(), $urandom());
      end else if (k < 35) begin
        queue_req(FN_RENDER, 1'($urandom()), SPACE_CP, 8'($urandom()), pick_start(),
                  pick_start(), $urandom());
      end else begin
        code = known_codes[$urandom_range(known_codes.size() - 1)];
        queue_req(FN_RENDER, ($urandom_range(99) < 30), code, 8'($urandom()),
                  pick_start(), pick_start(), $urandom());
      end
    end
  endtask

  // driver: one request held on the input channel until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_glyph(cur_req);
      end
      if (!in_valid || in_ready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_req = req_q.pop_front();
          cur_req <= next_req;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted vertex with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected vertex, expected none, got x=%h y=%h code=%h", $time,
                   out_vertex_x, out_vertex_y, out_char_code);
          err_cnt++;
        end else begin
          want_v = vertex_q.pop_front();
          check_field("vertex_x", 32'(want_v.x), 32'(out_vertex_x));
          check_field("vertex_y", 32'(want_v.y), 32'(out_vertex_y));
          check_field("uv_packed", 32'(want_v.uv), 32'(out_uv_packed));
          check_field("vertex_color", want_v.color, out_vertex_color);
          check_field("char_code", 32'(want_v.id), 32'(out_char_code));
          check_field("last_vertex", 32'(want_v.last), 32'(out_last_vertex));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: table extremes, reversed columns, spaces, pen saturation
    queue_req(FN_LOAD, 1'b0, 16'h0041, 8'h07, 16'h0000, 16'h0000, 32'h0);
    queue_req(FN_LOAD, 1'b1, 16'h0042, 8'hF0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    queue_req(FN_LOAD, 1'b0, 16'hFFFF, 8'hFF, 16'h7FFF, 16'h8000, 32'h12345678);
    queue_req(FN_LOAD, 1'b0, 16'h0000, 8'h00, 16'h0000, 16'h0000, 32'h0);
    queue_req(FN_LOAD, 1'b0, SPACE_CP, 8'h5A, 16'h0000, 16'h0000, 32'h0);
    queue_req(FN_RENDER, 1'b1, 16'h0041, 8'h00, 16'h0000, 16'h0000, 32'h00000000);
    queue_req(FN_RENDER, 1'b0, 16'h0042, 8'hFF, 16'h1234, 16'h5678, 32'hFFFFFFFF);
    queue_req(FN_RENDER, 1'b0, SPACE_CP, 8'h00, 16'h0000, 16'h0000, 32'h0);
    queue_req(FN_RENDER, 1'b0, 16'h0041, 8'h00, 16'h0000, 16'h0000, 32'hA5A5A5A5);
    queue_req(FN_RENDER, 1'b1, SPACE_CP, 8'h00, 16'h7FFF, 16'h0010, 32'h0);
    queue_req(FN_RENDER, 1'b0, 16'h0041, 8'h00, 16'h0000, 16'h0000, 32'h5A5A5A5A);
    queue_req(FN_RENDER, 1'b1, 16'hFFFF, 8'h00, 16'h7FFF, 16'h7FFF, 32'h80000001);
    queue_req(FN_RENDER, 1'b1, 16'h0042, 8'h00, 16'h8000, 16'h8000, 32'h00FF00FF);
    queue_req(FN_RENDER, 1'b1, 16'h0000, 8'h00, 16'hFFFF, 16'h7FF0, 32'hFF00FF00);
    queue_req(FN_LOAD, 1'b0, 16'h0041, 8'h0F, 16'h0000, 16'h0000, 32'h0);
    queue_req(FN_RENDER, 1'b1, 16'h0041, 8'h00, 16'h8000, 16'h0000, 32'h11111111);
    queue_req(FN_RENDER, 1'b0, 16'hFFFF, 8'h00, 16'h0000, 16'h0000, 32'h22222222);
    queue_req(FN_RENDER, 1'b0, 16'h0042, 8'h00, 16'h0000, 16'h0000, 32'h33333333);
    queue_req(FN_LOAD, 1'b0, 16'h8000, 8'hA5, 16'h0000, 16'h0000, 32'h0);
    queue_req(FN_RENDER, 1'b1, 16'h8000, 8'h00, 16'h0100, 16'hFF00, 32'hDEADBEEF);
    queue_req(FN_RENDER, 1'b0, SPACE_CP, 8'h00, 16'h0000, 16'h0000, 32'h0);
    queue_req(FN_RENDER, 1'b0, 16'h8000, 8'h00, 16'h0000, 16'h0000, 32'hCAFEF00D);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      gen_random(27);
      do begin
        @(negedge clk);
      end while (req_q.size() != 0 || in_valid || vertex_q.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
